### src/jsm_pkg.sv
`timescale 1ns / 1ps
package jsm_pkg;

  localparam int NUM_SLOTS = 3;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t [NUM_SLOTS-1:0] slot;
    logic [1:0]           cnt;
  } bundle_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

  function automatic logic is_ws(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

endpackage

### src/jsm_front.sv
`timescale 1ns / 1ps
module jsm_front import jsm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [7:0] in_byte,
  input  logic      end_of_text,
  input  q_status_t q_status,
  output logic      push,
  output bundle_t   push_data
);

  typedef struct packed {
    logic [7:0] held_byte;
    logic       held_valid;
    logic       skip_next;
    logic       in_line_comment;
    logic       in_block_comment;
    logic       in_single_quote;
    logic       in_double_quote;
    logic [7:0] pending_byte;
    logic       pending_valid;
    logic       output_nonempty;
    logic       seen_nonspace;
  } st_t;

  typedef struct packed {
    st_t        s;
    logic       emit;
    logic [7:0] data;
  } proc_t;

  function automatic proc_t proc(st_t s, logic [7:0] c, logic hn, logic [7:0] nx);
    proc_t r;
    logic do_app;
    logic kill;
    logic [7:0] ab;
    logic after_open;
    logic before_close;
    logic punct;
    r = '0;
    r.s = s;
    do_app = 1'b0;
    kill = 1'b0;
    ab = c;
    after_open = s.held_byte == CH_LPAREN || s.held_byte == CH_LBRACK ||
                 s.held_byte == CH_LBRACE;
    before_close = hn && (nx == CH_RPAREN || nx == CH_RBRACK || nx == CH_RBRACE);
    punct = c == CH_SEMI || c == CH_COMMA || c == CH_LBRACE || c == CH_RBRACE ||
            c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACK || c == CH_RBRACK ||
            c == CH_COLON;
    if (c == CH_SQUOTE && !s.in_double_quote && !s.in_block_comment &&
        !s.in_line_comment) begin
      r.s.in_single_quote = !s.in_single_quote;
    end else if (c == CH_DQUOTE && !s.in_single_quote && !s.in_block_comment &&
                 !s.in_line_comment) begin
      r.s.in_double_quote = !s.in_double_quote;
    end
    priority if (r.s.in_single_quote || r.s.in_double_quote) begin
      do_app = 1'b1;
    end else if (hn && c == CH_SLASH && nx == CH_SLASH) begin
      r.s.in_line_comment = 1'b1;
    end else if (hn && c == CH_SLASH && nx == CH_STAR) begin
      r.s.in_block_comment = 1'b1;
      r.s.skip_next = 1'b1;
    end else if (s.in_line_comment) begin
      if (c == CH_LF) begin
        r.s.in_line_comment = 1'b0;
        do_app = 1'b1;
      end
    end else if (s.in_block_comment) begin
      if (hn && c == CH_STAR && nx == CH_SLASH) begin
        r.s.in_block_comment = 1'b0;
        r.s.skip_next = 1'b1;
      end
    end else if (is_ws(c)) begin
      if (s.output_nonempty && !is_ws(s.held_byte) && !after_open && !before_close) begin
        do_app = 1'b1;
        ab = CH_SPACE;
      end
    end else begin
      kill = s.output_nonempty && s.held_byte == CH_SPACE && punct;
      do_app = 1'b1;
    end
    if (do_app) begin
      r.emit = s.held_valid && !kill;
      r.data = s.held_byte;
      r.s.held_byte = ab;
      r.s.seen_nonspace = s.seen_nonspace || !is_ws(ab);
      r.s.held_valid = r.s.seen_nonspace;
      r.s.output_nonempty = 1'b1;
    end
    return r;
  endfunction

  st_t     st;
  st_t     st_next;
  bundle_t bnd;
  proc_t   p0;
  proc_t   p1;
  st_t     s_mid;
  res_t    fin;
  logic    accept;

  assign in_ready = !q_status.full;
  assign accept = in_valid && in_ready;

  always_comb begin
    logic [1:0] n;
    n = 2'd0;
    bnd = '0;
    fin = '0;
    p0 = '0;
    p1 = '0;
    s_mid = st;
    if (st.pending_valid) begin
      p0 = proc(st, st.pending_byte, 1'b1, in_byte);
      s_mid = p0.s;
    end
    if (s_mid.skip_next) begin
      s_mid.skip_next = 1'b0;
      s_mid.pending_valid = 1'b0;
    end else begin
      s_mid.pending_byte = in_byte;
      s_mid.pending_valid = 1'b1;
    end
    st_next = s_mid;
    if (p0.emit) begin
      bnd.slot[n] = '{data: p0.data, has: 1'b1, last: 1'b0};
      n = n + 2'd1;
    end
    if (end_of_text) begin
      if (s_mid.pending_valid) begin
        p1 = proc(s_mid, s_mid.pending_byte, 1'b0, 8'h00);
      end else begin
        p1.s = s_mid;
      end
      if (p1.emit) begin
        bnd.slot[n] = '{data: p1.data, has: 1'b1, last: 1'b0};
        n = n + 2'd1;
      end
      fin.has = p1.s.held_valid && !is_ws(p1.s.held_byte);
      fin.data = fin.has ? p1.s.held_byte : 8'h00;
      fin.last = 1'b1;
      bnd.slot[n] = fin;
      n = n + 2'd1;
      st_next = '0;
    end
    bnd.cnt = n;
  end

  assign push = accept && (bnd.cnt != 2'd0);
  assign push_data = bnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

endmodule

### src/jsm_queue.sv
`timescale 1ns / 1ps
module jsm_queue import jsm_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  bundle_t   push_data,
  input  logic      pop,
  output q_status_t q_status,
  output bundle_t   head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  bundle_t       mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign q_status.not_empty = count != '0;
  assign q_status.full = count == FULL_CNT;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!q_status.full || pop))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_status.not_empty)
    else $error("pop from empty queue");
  a_no_empty_bundle: assert property (@(posedge clk) disable iff (rst)
    push |-> push_data.cnt != 2'd0)
    else $error("empty bundle pushed");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count out of range");
`endif

endmodule

### src/jsm_back.sv
`timescale 1ns / 1ps
module jsm_back import jsm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  q_status_t  q_status,
  input  bundle_t    head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       end_of_output
);

  logic [1:0] idx;
  logic       take;
  res_t       cur;

  assign cur = head.slot[idx];
  assign out_valid = q_status.not_empty;
  assign out_byte = cur.data;
  assign has_byte = cur.has;
  assign end_of_output = cur.last;
  assign take = out_valid && out_ready;
  assign pop = take && (idx == head.cnt - 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= pop ? 2'd0 : idx + 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> idx < head.cnt)
    else $error("slot index beyond bundle");
  a_last_pops: assert property (@(posedge clk) disable iff (rst)
    (take && end_of_output) |-> pop)
    else $error("end marker not last in bundle");
  a_idx_clear: assert property (@(posedge clk) disable iff (rst)
    pop |=> idx == 2'd0)
    else $error("slot index not cleared after pop");
`endif

endmodule

### src/js_comment_whitespace_minifier_unit.sv
// A bundle queue of DEPTH entries separates the input side from the output side.
// Throughput: one input item per cycle unless the queue is full; an item yields
// at most one result, except the end-of-text item, which yields up to three, sent
// one per cycle by the output side while out_ready is high.
// Reset (synchronous, active high) clears all text state and empties the queue.
`timescale 1ns / 1ps
module js_comment_whitespace_minifier_unit import jsm_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       end_of_output
);

  q_status_t q_status;
  logic      push;
  logic      pop;
  bundle_t   push_data;
  bundle_t   head;

  jsm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .end_of_text(end_of_text),
    .q_status   (q_status),
    .push       (push),
    .push_data  (push_data)
  );

  jsm_queue #(.DEPTH(DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .q_status (q_status),
    .head     (head)
  );

  jsm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .has_byte     (has_byte),
    .end_of_output(end_of_output)
  );

endmodule

### tb/sv/minify_checker.sv
`timescale 1ns / 1ps
module minify_checker import jsm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       has_byte,
  input  logic       end_of_output,
  output int         errors,
  output int         waiting
);

  logic [7:0] held_byte;
  logic [7:0] look_byte;
  bit         held_ok;
  bit         look_ok;
  bit         skip_one;
  bit         in_line;
  bit         in_block;
  bit         in_sq;
  bit         in_dq;
  bit         out_started;
  bit         got_text;

  res_t expected_bytes[$];
  res_t want;
  res_t got;

  function automatic bit ws_char(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  task automatic clear_text();
    held_byte   = 8'h00;
    look_byte   = 8'h00;
    held_ok     = 1'b0;
    look_ok     = 1'b0;
    skip_one    = 1'b0;
    in_line     = 1'b0;
    in_block    = 1'b0;
    in_sq       = 1'b0;
    in_dq       = 1'b0;
    out_started = 1'b0;
    got_text    = 1'b0;
  endtask

  task automatic expect_byte(logic [7:0] b, bit has, bit last);
    res_t r;
    r.data = has ? b : 8'h00;
    r.has  = has;
    r.last = last;
    expected_bytes = {expected_bytes, r};
  endtask

  // emits the previously held byte, keeps the new one back
  task automatic hold_char(logic [7:0] b);
    if (held_ok) expect_byte(held_byte, 1'b1, 1'b0);
    held_byte = b;
    if (!ws_char(b)) got_text = 1'b1;
    held_ok = got_text;
    out_started = 1'b1;
  endtask

  task automatic minify_char(logic [7:0] c, bit has_nx, logic [7:0] nx);
    bit after_open;
    bit before_close;
    bit punct;
    if (c == CH_SQUOTE && !in_dq && !in_block && !in_line) in_sq = !in_sq;
    else if (c == CH_DQUOTE && !in_sq && !in_block && !in_line) in_dq = !in_dq;

    if (in_sq || in_dq) begin
      hold_char(c);
    end else if (has_nx && c == CH_SLASH && nx == CH_SLASH) begin
      in_line = 1'b1;
    end else if (has_nx && c == CH_SLASH && nx == CH_STAR) begin
      in_block = 1'b1;
      skip_one = 1'b1;
    end else if (in_line) begin
      if (c == CH_LF) begin
        in_line = 1'b0;
        hold_char(c);
      end
    end else if (in_block) begin
      if (has_nx && c == CH_STAR && nx == CH_SLASH) begin
        in_block = 1'b0;
        skip_one = 1'b1;
      end
    end else if (ws_char(c)) begin
      after_open = held_byte == CH_LPAREN || held_byte == CH_LBRACK ||
                   held_byte == CH_LBRACE;
      before_close = has_nx && (nx == CH_RPAREN || nx == CH_RBRACK || nx == CH_RBRACE);
      if (out_started && !ws_char(held_byte) && !after_open && !before_close)
        hold_char(CH_SPACE);
    end else begin
      punct = c == CH_SEMI || c == CH_COMMA || c == CH_LBRACE || c == CH_RBRACE ||
              c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACK || c == CH_RBRACK ||
              c == CH_COLON;
      if (out_started && held_byte == CH_SPACE && punct) held_ok = 1'b0;
      hold_char(c);
    end
  endtask

  task automatic take_item(logic [7:0] b, bit eot);
    if (look_ok) minify_char(look_byte, 1'b1, b);
    if (skip_one) begin
      skip_one = 1'b0;
      look_ok = 1'b0;
    end else begin
      look_byte = b;
      look_ok = 1'b1;
    end
    if (eot) begin
      if (look_ok) begin
        minify_char(look_byte, 1'b0, 8'h00);
        look_ok = 1'b0;
      end
      if (held_ok && !ws_char(held_byte)) expect_byte(held_byte, 1'b1, 1'b1);
      else expect_byte(8'h00, 1'b0, 1'b1);
      clear_text();
    end
  endtask

  task automatic report(bit orphan);
    errors++;
    if (errors <= 10) begin
      if (orphan)
        $display("%0t: unexpected item byte %02h has %0b last %0b", $realtime,
                 got.data, got.has, got.last);
      else
        $display("%0t: mismatch exp byte %02h has %0b last %0b, got byte %02h has %0b last %0b",
                 $realtime, want.data, want.has, want.last, got.data, got.has, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_text();
      expected_bytes.delete();
      errors = 0;
    end else begin
      if (in_valid && in_ready) take_item(in_byte, end_of_text);
      if (out_valid && out_ready) begin
        got.data = out_byte;
        got.has  = has_byte;
        got.last = end_of_output;
        if (expected_bytes.size() == 0) begin
          report(1'b1);
        end else begin
          want = expected_bytes.pop_front();
          if (want.data !== got.data || want.has !== got.has || want.last !== got.last)
            report(1'b0);
        end
      end
    end
    waiting = expected_bytes.size();
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb import jsm_pkg::*; ();

  localparam int CYCLE_LIMIT = 200000;
  localparam int TARGET_ITEMS = 470;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       end_of_text;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       end_of_output;

  int errors;
  int waiting;
  int cycles = 0;
  int sent_items = 0;
  bit calm_in = 1'b0;
  bit calm_out = 1'b0;

  js_comment_whitespace_minifier_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .end_of_text(end_of_text),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .has_byte(has_byte),
    .end_of_output(end_of_output)
  );

  minify_checker chk (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .end_of_text(end_of_text),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .has_byte(has_byte),
    .end_of_output(end_of_output),
    .errors(errors),
    .waiting(waiting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(logic [7:0] b, bit eot);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_text(string s, bit close);
    for (int i = 0; i < s.len(); i++) send_item(s[i], close && i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_ws();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_punct();
    case ($urandom_range(0, 11))
      0: return CH_SEMI;
      1: return CH_COMMA;
      2: return CH_LBRACE;
      3: return CH_RBRACE;
      4: return CH_LPAREN;
      5: return CH_RPAREN;
      6: return CH_LBRACK;
      7: return CH_RBRACK;
      8: return CH_COLON;
      9: return 8'h3D;
      10: return 8'h2E;
      default: return 8'h2B;
    endcase
  endfunction

  function automatic logic [7:0] pick_odd();
    case ($urandom_range(0, 4))
      0: return CH_SLASH;
      1: return CH_STAR;
      2: return CH_SQUOTE;
      3: return CH_DQUOTE;
      default: return 8'h5C;
    endcase
  endfunction

  function automatic logic [7:0] pick_filler();
    case ($urandom_range(0, 7))
      0, 1, 2: return 8'(8'h61 + $urandom_range(0, 25));
      3: return pick_ws();
      4: return pick_punct();
      5, 6: return pick_odd();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly token-shaped script text, with some broken comments and noise
  task automatic send_random_text();
    logic [7:0] txt[$];
    logic [7:0] q;
    int ntok;
    int kind;
    int n;
    ntok = $urandom_range(1, 8);
    calm_in = $urandom_range(0, 3) == 0;
    for (int t = 0; t < ntok; t++) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        n = $urandom_range(1, 4);
        repeat (n) txt = {txt, ($urandom_range(0, 3) == 0) ? 8'(8'h30 + $urandom_range(0, 9))
                                                           : 8'(8'h61 + $urandom_range(0, 25))};
      end else if (kind < 45) begin
        n = $urandom_range(1, 3);
        repeat (n) txt = {txt, pick_ws()};
      end else if (kind < 62) begin
        txt = {txt, pick_punct()};
      end else if (kind < 70) begin
        txt = {txt, CH_SLASH};
        txt = {txt, CH_SLASH};
        n = $urandom_range(0, 3);
        repeat (n) txt = {txt, pick_filler()};
        if ($urandom_range(0, 4) != 0) txt = {txt, CH_LF};
      end else if (kind < 78) begin
        txt = {txt, CH_SLASH};
        txt = {txt, CH_STAR};
        n = $urandom_range(0, 3);
        repeat (n) txt = {txt, pick_filler()};
        if ($urandom_range(0, 4) != 0) begin
          txt = {txt, CH_STAR};
          txt = {txt, CH_SLASH};
        end
      end else if (kind < 88) begin
        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        txt = {txt, q};
        n = $urandom_range(0, 3);
        repeat (n) txt = {txt, pick_filler()};
        txt = {txt, q};
      end else if (kind < 92) begin
        txt = {txt, pick_odd()};
      end else begin
        txt = {txt, 8'($urandom_range(0, 255))};
      end
    end
    foreach (txt[i]) send_item(txt[i], i == txt.size() - 1);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    end_of_text = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero byte, leading ws, spaces around brackets and before comma, top byte
    send_item(8'h00, 1'b0);
    send_text(" (\ta ,\013)\014", 1'b0);
    send_item(8'hFF, 1'b1);
    // no escapes, markers in strings, block comment opened inside a line comment
    send_text("'\\'\"'/*\"//y/*\n*/z ", 1'b1);
    // whitespace only
    send_text(" \n", 1'b1);
    // single byte text
    send_text("x", 1'b1);

    while (sent_items < TARGET_ITEMS) send_random_text();
    in_valid <= 1'b0;

    while (waiting != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (errors == 0 && waiting == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) calm_out = !calm_out;
      stall = calm_out ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

endmodule
